FILE: sv/gpp_pkg.sv
`default_nettype none

package gpp_pkg;

    localparam int GRID_SIDE   = 8;
    localparam int MAX_LINES   = 1024;

    localparam int ROW_W       = $clog2(GRID_SIDE);
    localparam int STRIDE_W    = 3;
    localparam int ROW_MASK_W  = 8;
    localparam int MASK_W      = 64;
    localparam int MASK_IDX_W  = 6;
    localparam int LINE_W      = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CNT_W       = $clog2(MAX_LINES + 1);
    localparam int MASK_DEPTH  = MAX_LINES * 8;
    localparam int MADDR_W     = LINE_W + STRIDE_W;
    localparam int REG_W       = 7;
    localparam int COORD_W     = 8;
    localparam int DIFF_W      = 9;
    localparam int DUR_W       = 16;
    localparam int INDEX_W     = 10;

    typedef enum logic [2:0] {
        ACT_CLEAR = 3'd0,
        ACT_ADD   = 3'd1,
        ACT_GOTO  = 3'd2,
        ACT_NEXT  = 3'd3,
        ACT_PREV  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BOUNDS = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic {
        REG_X_LOWEST  = 1'b0,
        REG_Y_HIGHEST = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic add;
        logic flush;
    } build_ctl_t;

endpackage

`default_nettype wire

FILE: sv/grid_pattern_program_player_core.sv
`default_nettype none

// Grid line program player. An item is taken when start is high and busy is low;
// each result word shows for one cycle with result_valid and cannot be held off,
// last marking the final word of an item. Clear, selection on an empty program,
// an add without commit and an unknown action leave busy low (result, if any,
// the cycle after). A commit writes one row mask to the mask memory per cycle,
// row by row. A selection reads the line's GRID_SIDE row masks (S_LOAD), lets
// the last read land (S_FILL), then emits one point per cycle (S_SCAN), except
// where it steps from a row to the next one, which gives no point.
// The memories need no clearing after reset.
module grid_pattern_program_player_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [gpp_pkg::REG_W-1:0]           cfg_data,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [2:0]                          action,
    input  wire logic signed [7:0]                   x,
    input  wire logic signed [7:0]                   y,
    input  wire logic                                point_present,
    input  wire logic                                last_of_line,
    input  wire logic [15:0]                         duration,
    input  wire logic [9:0]                          line_number,
    output logic                                     result_valid,
    output logic [1:0]                               status,
    output logic signed [7:0]                        point_x,
    output logic signed [7:0]                        point_y,
    output logic                                     point_valid,
    output logic [15:0]                              line_duration,
    output logic [9:0]                               line_index,
    output logic                                     last
);

    import gpp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMMIT,
        S_LOAD,
        S_FILL,
        S_SCAN
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic signed [REG_W-1:0]    x_lowest_reg;
    logic signed [REG_W-1:0]    x_lowest_next;
    logic signed [REG_W-1:0]    y_highest_reg;
    logic signed [REG_W-1:0]    y_highest_next;
    logic [CNT_W-1:0]           line_count_reg;
    logic [CNT_W-1:0]           line_count_next;
    logic [LINE_W-1:0]          cur_reg;
    logic [LINE_W-1:0]          cur_next;
    logic [ROW_W-1:0]           row_reg;
    logic [ROW_W-1:0]           row_next;
    logic [DUR_W-1:0]           dur_in_reg;
    logic [DUR_W-1:0]           dur_in_next;
    logic [DUR_W-1:0]           dur_sel_reg;
    logic [DUR_W-1:0]           dur_sel_next;
    logic [ROW_MASK_W-1:0]      rows_reg [GRID_SIDE];
    logic [ROW_MASK_W-1:0]      rows_next [GRID_SIDE];
    logic                       cap_valid_reg;
    logic                       cap_valid_next;
    logic [ROW_W-1:0]           cap_row_reg;
    logic [ROW_W-1:0]           cap_row_next;

    logic                       res_valid_reg;
    logic                       res_valid_next;
    status_t                    status_reg;
    status_t                    status_next;
    logic [COORD_W-1:0]         px_reg;
    logic [COORD_W-1:0]         px_next;
    logic [COORD_W-1:0]         py_reg;
    logic [COORD_W-1:0]         py_next;
    logic                       pv_reg;
    logic                       pv_next;
    logic [DUR_W-1:0]           dur_out_reg;
    logic [DUR_W-1:0]           dur_out_next;
    logic [INDEX_W-1:0]         idx_reg;
    logic [INDEX_W-1:0]         idx_next;
    logic                       last_reg;
    logic                       last_next;

    build_ctl_t                 build_ctl;
    logic [MASK_W-1:0]          build_masks;
    logic                       build_bad;

    logic                       mask_we;
    logic [MADDR_W-1:0]         mask_waddr;
    logic                       mask_re;
    logic [MADDR_W-1:0]         mask_raddr;
    logic [ROW_MASK_W-1:0]      mask_rdata;
    logic                       dur_we;
    logic                       dur_re;
    logic [DUR_W-1:0]           dur_rdata;

    logic [CNT_W-1:0]           last_line;
    logic [INDEX_W:0]           target_ext;
    logic [ROW_MASK_W-1:0]      cur_mask;
    logic [ROW_MASK_W-1:0]      rest_mask;
    logic [STRIDE_W-1:0]        col;
    logic                       later_rows;

    gpp_build u_build (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (build_ctl),
        .x             (x),
        .y             (y),
        .point_present (point_present),
        .x_lowest      (x_lowest_reg),
        .y_highest     (y_highest_reg),
        .masks         (build_masks),
        .bad           (build_bad)
    );

    gpp_ram #(
        .WIDTH (ROW_MASK_W),
        .DEPTH (MASK_DEPTH)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (build_masks[{STRIDE_W'(row_reg), 3'b000} +: ROW_MASK_W]),
        .re    (mask_re),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    gpp_ram #(
        .WIDTH (DUR_W),
        .DEPTH (MAX_LINES)
    ) u_dur_ram (
        .clk   (clk),
        .we    (dur_we),
        .waddr (line_count_reg[LINE_W-1:0]),
        .wdata (dur_in_reg),
        .re    (dur_re),
        .raddr (cur_reg),
        .rdata (dur_rdata)
    );

    assign mask_waddr = {line_count_reg[LINE_W-1:0], STRIDE_W'(row_reg)};
    assign mask_raddr = {cur_reg, STRIDE_W'(row_reg)};

    always_comb
    begin
        last_line  = line_count_reg - CNT_W'(1);
        target_ext = {1'b0, line_number};
        cur_mask   = rows_reg[row_reg];
        rest_mask  = cur_mask & (cur_mask - ROW_MASK_W'(1));
        col        = '0;
        for (int i = ROW_MASK_W - 1; i >= 0; i--)
        begin
            if (cur_mask[i])
            begin
                col = STRIDE_W'(i);
            end
        end
        later_rows = 1'b0;
        for (int r = 0; r < GRID_SIDE; r++)
        begin
            if ((ROW_W'(r) > row_reg) && (rows_reg[r] != '0))
            begin
                later_rows = 1'b1;
            end
        end

        state_next      = state_reg;
        x_lowest_next   = x_lowest_reg;
        y_highest_next  = y_highest_reg;
        line_count_next = line_count_reg;
        cur_next        = cur_reg;
        row_next        = row_reg;
        dur_in_next     = dur_in_reg;
        dur_sel_next    = dur_sel_reg;
        rows_next       = rows_reg;
        cap_valid_next  = 1'b0;
        cap_row_next    = row_reg;

        res_valid_next  = 1'b0;
        status_next     = ST_OK;
        px_next         = '0;
        py_next         = '0;
        pv_next         = 1'b0;
        dur_out_next    = '0;
        idx_next        = '0;
        last_next       = 1'b0;

        build_ctl       = '0;
        mask_we         = 1'b0;
        mask_re         = 1'b0;
        dur_we          = 1'b0;
        dur_re          = 1'b0;

        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_X_LOWEST:  x_lowest_next  = cfg_data;
                REG_Y_HIGHEST: y_highest_next = cfg_data;
                default: ;
            endcase
        end

        if (cap_valid_reg)
        begin
            rows_next[cap_row_reg] = mask_rdata;
            if (cap_row_reg == '0)
            begin
                dur_sel_next = dur_rdata;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action_t'(action))
                        ACT_CLEAR:
                        begin
                            line_count_next = '0;
                            cur_next        = '0;
                            build_ctl.flush = 1'b1;
                            res_valid_next  = 1'b1;
                            last_next       = 1'b1;
                        end
                        ACT_ADD:
                        begin
                            build_ctl.add = 1'b1;
                            if (last_of_line)
                            begin
                                dur_in_next = duration;
                                row_next    = '0;
                                state_next  = S_COMMIT;
                            end
                        end
                        ACT_GOTO, ACT_NEXT, ACT_PREV:
                        begin
                            if (line_count_reg == '0)
                            begin
                                res_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                if (action_t'(action) == ACT_GOTO)
                                begin
                                    cur_next = ((INDEX_W+1)'(target_ext)
                                                < (INDEX_W+1)'(last_line))
                                             ? LINE_W'(line_number)
                                             : LINE_W'(last_line);
                                end
                                else if (action_t'(action) == ACT_NEXT)
                                begin
                                    cur_next = (CNT_W'(cur_reg) >= last_line)
                                             ? '0 : cur_reg + LINE_W'(1);
                                end
                                else
                                begin
                                    cur_next = ((cur_reg == '0)
                                                || (CNT_W'(cur_reg) >= line_count_reg))
                                             ? LINE_W'(last_line)
                                             : cur_reg - LINE_W'(1);
                                end
                                row_next   = '0;
                                state_next = S_LOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_COMMIT:
            begin
                if (line_count_reg == CNT_W'(MAX_LINES))
                begin
                    build_ctl.flush = 1'b1;
                    res_valid_next  = 1'b1;
                    status_next     = ST_FULL;
                    last_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (build_bad)
                begin
                    build_ctl.flush = 1'b1;
                    res_valid_next  = 1'b1;
                    status_next     = ST_BOUNDS;
                    last_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    mask_we  = 1'b1;
                    row_next = row_reg + ROW_W'(1);
                    if (row_reg == ROW_W'(GRID_SIDE - 1))
                    begin
                        dur_we          = 1'b1;
                        build_ctl.flush = 1'b1;
                        res_valid_next  = 1'b1;
                        dur_out_next    = dur_in_reg;
                        idx_next        = INDEX_W'(line_count_reg[LINE_W-1:0]);
                        last_next       = 1'b1;
                        line_count_next = line_count_reg + CNT_W'(1);
                        state_next      = S_IDLE;
                    end
                end
            end

            S_LOAD:
            begin
                mask_re        = 1'b1;
                dur_re         = (row_reg == '0);
                cap_valid_next = 1'b1;
                row_next       = row_reg + ROW_W'(1);
                if (row_reg == ROW_W'(GRID_SIDE - 1))
                begin
                    state_next = S_FILL;
                end
            end

            S_FILL:
            begin
                row_next   = '0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (cur_mask != '0)
                begin
                    rows_next[row_reg] = rest_mask;
                    res_valid_next     = 1'b1;
                    px_next = {x_lowest_reg[REG_W-1], x_lowest_reg}
                            + {{(COORD_W-STRIDE_W){1'b0}}, col};
                    py_next = {y_highest_reg[REG_W-1], y_highest_reg}
                            - COORD_W'(row_reg);
                    pv_next      = 1'b1;
                    dur_out_next = dur_sel_reg;
                    idx_next     = INDEX_W'(cur_reg);
                    last_next    = (rest_mask == '0) && !later_rows;
                    if ((rest_mask == '0) && !later_rows)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (later_rows)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    // line with no point
                    res_valid_next = 1'b1;
                    dur_out_next   = dur_sel_reg;
                    idx_next       = INDEX_W'(cur_reg);
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            x_lowest_reg   <= -REG_W'(4);
            y_highest_reg  <= REG_W'(3);
            line_count_reg <= '0;
            cur_reg        <= '0;
            row_reg        <= '0;
            cap_valid_reg  <= 1'b0;
            cap_row_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            x_lowest_reg   <= x_lowest_next;
            y_highest_reg  <= y_highest_next;
            line_count_reg <= line_count_next;
            cur_reg        <= cur_next;
            row_reg        <= row_next;
            cap_valid_reg  <= cap_valid_next;
            cap_row_reg    <= cap_row_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dur_in_reg  <= dur_in_next;
        dur_sel_reg <= dur_sel_next;
        rows_reg    <= rows_next;
        status_reg  <= status_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        pv_reg      <= pv_next;
        dur_out_reg <= dur_out_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = res_valid_reg;
    assign status        = status_reg;
    assign point_x       = px_reg;
    assign point_y       = py_reg;
    assign point_valid   = pv_reg;
    assign line_duration = dur_out_reg;
    assign line_index    = idx_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_count_reg <= CNT_W'(MAX_LINES))
        else $error("line count above table size");

    a_point_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && pv_reg) |-> (status_reg == ST_OK))
        else $error("point word with non-ok status");

    a_point_line: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && pv_reg) |-> (CNT_W'(idx_reg) < line_count_reg))
        else $error("point word from a line not in the program");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_LOAD) || (state_reg == S_SCAN)) |-> (line_count_reg != '0))
        else $error("playback on an empty program");

    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(mask_we && mask_re))
        else $error("mask memory written and read in one cycle");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && last_reg) |-> (state_reg == S_IDLE))
        else $error("final word while still busy");
`endif

endmodule

`default_nettype wire

FILE: sv/gpp_ram.sv
`default_nettype none

module gpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/gpp_build.sv
`default_nettype none

module gpp_build (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire gpp_pkg::build_ctl_t                 ctl,
    input  wire logic signed [gpp_pkg::COORD_W-1:0]  x,
    input  wire logic signed [gpp_pkg::COORD_W-1:0]  y,
    input  wire logic                                point_present,
    input  wire logic signed [gpp_pkg::REG_W-1:0]    x_lowest,
    input  wire logic signed [gpp_pkg::REG_W-1:0]    y_highest,
    output logic             [gpp_pkg::MASK_W-1:0]   masks,
    output logic                                     bad
);

    import gpp_pkg::*;

    logic [MASK_W-1:0]        masks_reg;
    logic [MASK_W-1:0]        masks_next;
    logic                     bad_reg;
    logic                     bad_next;
    logic signed [DIFF_W-1:0] col_d;
    logic signed [DIFF_W-1:0] row_d;
    logic                     in_grid;
    logic [MASK_IDX_W-1:0]    bit_idx;

    always_comb
    begin
        col_d   = {x[COORD_W-1], x} - {{2{x_lowest[REG_W-1]}}, x_lowest};
        row_d   = {{2{y_highest[REG_W-1]}}, y_highest} - {y[COORD_W-1], y};
        in_grid = !col_d[DIFF_W-1] && (col_d[DIFF_W-2:0] < (DIFF_W-1)'(GRID_SIDE))
               && !row_d[DIFF_W-1] && (row_d[DIFF_W-2:0] < (DIFF_W-1)'(GRID_SIDE));
        bit_idx = {row_d[2:0], col_d[2:0]};

        masks_next = masks_reg;
        bad_next   = bad_reg;
        if (ctl.flush)
        begin
            masks_next = '0;
            bad_next   = 1'b0;
        end
        else if (ctl.add && point_present)
        begin
            if (in_grid)
            begin
                masks_next = masks_reg | (MASK_W'(1) << bit_idx);
            end
            else
            begin
                bad_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masks_reg <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            masks_reg <= masks_next;
            bad_reg   <= bad_next;
        end
    end

    assign masks = masks_reg;
    assign bad   = bad_reg;

endmodule

`default_nettype wire
